// File: sv/yrcc_pkg.sv
`timescale 1ns / 1ps

package yrcc_pkg;

    // direction codes carried in tuser
    localparam logic FUNC_TO_RGB = 1'b0;
    localparam logic FUNC_TO_YCC = 1'b1;

    localparam int Q_SHIFT = 12;
    localparam int CLAMP_W = 20;                       // holds 255 << 12 plus half
    localparam logic [CLAMP_W-1:0] Q_MAX  = CLAMP_W'(255 << Q_SHIFT);
    localparam logic [CLAMP_W-1:0] Q_HALF = CLAMP_W'(1 << (Q_SHIFT - 1));

    typedef logic signed [8:0]  operand_t;   // centered or plain 8-bit component
    typedef logic signed [14:0] coef_t;      // Q12 weight, largest magnitude 8266
    typedef logic signed [23:0] prod_t;      // coef * operand
    typedef logic signed [24:0] sum_t;       // three products plus offset
    typedef logic [7:0]         pixel_t;

    typedef operand_t  operand_vec_t [3];
    typedef prod_t     prod_row_t [3];
    typedef prod_row_t prod_mat_t [3];
    typedef sum_t      sum_vec_t [3];

    // control traveling alongside each stage's payload
    typedef struct packed {
        logic valid;
        logic func;
    } pipe_ctl_t;

    // weight of input component col in output component row
    function automatic coef_t coef(input logic func, input logic [1:0] row,
                                   input logic [1:0] col);
        coef_t w;
        w = '0;
        if (func == FUNC_TO_RGB) begin
            case ({row, col})
                4'h0: w = 15'sd4768;   // R <- Y
                4'h2: w = 15'sd6537;   // R <- Cr
                4'h4: w = 15'sd4768;   // G <- Y
                4'h5: w = -15'sd1602;  // G <- Cb
                4'h6: w = -15'sd3330;  // G <- Cr
                4'h8: w = 15'sd4768;   // B <- Y
                4'h9: w = 15'sd8266;   // B <- Cb
                default: w = '0;
            endcase
        end
        else begin
            case ({row, col})
                4'h0: w = 15'sd1053;
                4'h1: w = 15'sd2064;
                4'h2: w = 15'sd401;
                4'h4: w = -15'sd606;
                4'h5: w = -15'sd1192;
                4'h6: w = 15'sd1798;
                4'h8: w = 15'sd1798;
                4'h9: w = -15'sd1507;
                4'hA: w = -15'sd291;
                default: w = '0;
            endcase
        end
        return w;
    endfunction

    // constant term added to each sum (RGB -> YCbCr only)
    function automatic sum_t offset(input logic func, input logic [1:0] row);
        sum_t o;
        o = '0;
        if (func == FUNC_TO_YCC) begin
            case (row)
                2'd0:    o = 25'sd65536;    // 16 << 12
                default: o = 25'sd524288;   // 128 << 12
            endcase
        end
        return o;
    endfunction

endpackage

// File: sv/ycbcr_rgb_color_converter_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | Signals                              | Word
// ---------+-----+--------------------------------------+-------------------------------
// s_axis   | in  | tvalid, tready, tdata[23:0], tuser   | in_a, in_b, in_c; tuser = func
// m_axis   | out | tvalid, tready, tdata[23:0]          | out_a, out_b, out_c
//
// One word per clock while m_axis does not stall; an accepted word passes four register
// stages (centering, products, sums, clamp/round) on its way to m_axis_tvalid.
// rst_n clears only the stage control bits (valid, func); the data registers are not reset.
// A stall on m_axis freezes all four stages together: s_axis_tready drops in the
// same cycle, nothing is dropped or duplicated, and bubbles are not squeezed out.
module ycbcr_rgb_color_converter_top
    import yrcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_a [7:0], in_b [15:8], in_c [23:16]
    input  logic        s_axis_tuser,   // func: 0 YCbCr->RGB, 1 RGB->YCbCr
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // out_a [7:0], out_b [15:8], out_c [23:16]
);

    logic      adv;
    pipe_ctl_t mid_ctl;
    prod_mat_t mid_prod;
    pixel_t    out_a;
    pixel_t    out_b;
    pixel_t    out_c;

    // whole pipe moves whenever the output slot is empty or being taken
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    yrcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_axis_tvalid),
        .func     (s_axis_tuser),
        .in_a     (s_axis_tdata[7:0]),
        .in_b     (s_axis_tdata[15:8]),
        .in_c     (s_axis_tdata[23:16]),
        .ctl      (mid_ctl),
        .prod     (mid_prod)
    );

    yrcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl       (mid_ctl),
        .prod      (mid_prod),
        .out_valid (m_axis_tvalid),
        .out_a     (out_a),
        .out_b     (out_b),
        .out_c     (out_c)
    );

    assign m_axis_tdata = {out_c, out_b, out_a};

    // accepted word with free-running pipe must show up after four stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 s_axis_tready ##1 s_axis_tready
            ##1 s_axis_tready |=> m_axis_tvalid)
        else $error("accepted word did not reach output after four stages");

    // RGB -> YCbCr results stay in studio range
    a_ycc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_TO_YCC)
            ##1 s_axis_tready ##1 s_axis_tready ##1 s_axis_tready
        |=> (m_axis_tdata[7:0] >= 8'd16) && (m_axis_tdata[7:0] <= 8'd240)
            && (m_axis_tdata[15:8] >= 8'd16) && (m_axis_tdata[15:8] <= 8'd240)
            && (m_axis_tdata[23:16] >= 8'd16) && (m_axis_tdata[23:16] <= 8'd240))
        else $error("YCbCr result outside 16..240");

endmodule

// File: sv/yrcc_front.sv
`timescale 1ns / 1ps

// Stage 1: operand centering (YCbCr->RGB only); stage 2: nine weighted products.
module yrcc_front
    import yrcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  logic      func,
    input  pixel_t    in_a,
    input  pixel_t    in_b,
    input  pixel_t    in_c,
    output pipe_ctl_t ctl,
    output prod_mat_t prod
);

    pipe_ctl_t    s1_ctl_reg, s1_ctl_next;
    operand_vec_t x_reg, x_next;
    pipe_ctl_t    s2_ctl_reg;
    prod_mat_t    prod_reg, prod_next;

    always_comb
    begin
        s1_ctl_next.valid = in_valid;
        s1_ctl_next.func  = func;
        if (func == FUNC_TO_RGB)
        begin
            x_next[0] = $signed({1'b0, in_a}) - 9'sd16;
            x_next[1] = $signed({1'b0, in_b}) - 9'sd128;
            x_next[2] = $signed({1'b0, in_c}) - 9'sd128;
        end
        else
        begin
            x_next[0] = $signed({1'b0, in_a});
            x_next[1] = $signed({1'b0, in_b});
            x_next[2] = $signed({1'b0, in_c});
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = coef(s1_ctl_reg.func, 2'(r), 2'(c)) * x_reg[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= x_next;
            prod_reg <= prod_next;
        end
    end

    assign ctl  = s2_ctl_reg;
    assign prod = prod_reg;

endmodule

// File: sv/yrcc_back.sv
`timescale 1ns / 1ps

// Stage 3: row sums plus offset; stage 4: clamp, round (RGB) or truncate (YCbCr), output word.
module yrcc_back
    import yrcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  pipe_ctl_t ctl,
    input  prod_mat_t prod,
    output logic      out_valid,
    output pixel_t    out_a,
    output pixel_t    out_b,
    output pixel_t    out_c
);

    pipe_ctl_t s3_ctl_reg;
    sum_vec_t  sum_reg, sum_next;
    logic      out_valid_reg;
    pixel_t    pix_reg [3];
    pixel_t    pix_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = sum_t'(prod[r][0]) + sum_t'(prod[r][1])
                        + sum_t'(prod[r][2]) + offset(ctl.func, 2'(r));
        end
    end

    always_comb
    begin
        logic [CLAMP_W-1:0] clamped;
        logic [CLAMP_W-1:0] rounded;
        for (int r = 0; r < 3; r++)
        begin
            if (sum_reg[r] < 0)
                clamped = '0;
            else if (sum_reg[r] > $signed({5'd0, Q_MAX}))
                clamped = Q_MAX;
            else
                clamped = sum_reg[r][CLAMP_W-1:0];
            // RGB rounds to nearest, YCbCr truncates
            rounded = (s3_ctl_reg.func == FUNC_TO_RGB) ? clamped + Q_HALF : clamped;
            pix_next[r] = rounded[CLAMP_W-1:Q_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_ctl_reg    <= ctl;
            out_valid_reg <= s3_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= sum_next;
            pix_reg <= pix_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_a     = pix_reg[0];
    assign out_b     = pix_reg[1];
    assign out_c     = pix_reg[2];

endmodule
